@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the blitter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define FBR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// Check that cons holds after ante, as a delayed implication.
`define FBR_ASSERT_IMP2(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("assertion failed in %m");

`endif

@@ rtl/fbr_pkg.sv @@
// Package with constants, opcodes and the command type of the blitter.
`default_nettype none

package fbr_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;
    localparam int PIXEL_COUNT   = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W        = $clog2(PIXEL_COUNT);
    localparam int X_W           = $clog2(SCREEN_WIDTH + 1);
    localparam int Y_W           = $clog2(SCREEN_HEIGHT + 1);

    localparam int OP_W   = 2;
    localparam int POS_W  = 16;
    localparam int SIZE_W = 10;
    localparam int PIX_W  = 16;
    localparam int CNT_W  = 10;
    localparam int EXT_W  = 18;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_FILL   = 2'd1,
        OP_SPRITE = 2'd2,
        OP_READ   = 2'd3
    } opcode_t;

    typedef struct packed {
        logic             is_read;
        logic             rd_on;
        logic [X_W-1:0]   x0;
        logic [X_W-1:0]   x1;
        logic [Y_W-1:0]   y0;
        logic [Y_W-1:0]   y1;
        logic [PIX_W-1:0] color;
    } cmd_t;

endpackage

`default_nettype wire

@@ rtl/framebuffer_rect_fill_sprite_blit.sv @@
// Top level of the 2D blitter: front end, command queue, back end and frame memory.
//
//   channel  | signals                                               | dir
//   ---------+-------------------------------------------------------+----
//   command  | in_valid in_ready opcode pos_x pos_y size_w size_h    | in
//            | color last_pixel                                      |
//   pixel    | out_valid out_ready pixel_out                         | out
//
// The front end takes one item per cycle while the four-entry queue has room.
// Clear writes every pixel, a fill each visible pixel and a sprite item at most one
// pixel, all through the single frame memory port.
// A read passes the RAM and output registers and waits for a free output register.
// Reset clears the control state only; frame memory contents stay undefined.
`default_nettype none

`include "assert_macros.svh"

module framebuffer_rect_fill_sprite_blit import fbr_pkg::*; (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [OP_W-1:0]         opcode,
    input  wire logic signed [POS_W-1:0] pos_x,
    input  wire logic signed [POS_W-1:0] pos_y,
    input  wire logic [SIZE_W-1:0]       size_w,
    input  wire logic [SIZE_W-1:0]       size_h,
    input  wire logic [PIX_W-1:0]        color,
    input  wire logic                    last_pixel,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [PIX_W-1:0]             pixel_out
);

    logic              q_push, q_ready, q_pop, q_valid;
    cmd_t              push_cmd, pop_cmd;
    logic              ram_en, ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [PIX_W-1:0]  ram_wdata, ram_rdata;

    fbr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .size_w     (size_w),
        .size_h     (size_h),
        .color      (color),
        .last_pixel (last_pixel),
        .q_push     (q_push),
        .q_cmd      (push_cmd),
        .q_ready    (q_ready)
    );

    fbr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_cmd    (pop_cmd)
    );

    fbr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (pop_cmd),
        .q_pop     (q_pop),
        .ram_en    (ram_en),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_out (pixel_out)
    );

    fbr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (PIXEL_COUNT)
    ) u_frame (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    `FBR_ASSERT_IMP(a_wr_in_range, ram_we, ram_addr < ADDR_W'(PIXEL_COUNT))
    `FBR_ASSERT_IMP(a_no_rd_during_draw, ram_en && !ram_we, !q_valid || q_pop)
    `FBR_ASSERT_IMP(a_full_has_work, !in_ready, q_valid)
    `FBR_ASSERT_IMP2(a_read_returns, ram_en && !ram_we, out_valid)

endmodule

`default_nettype wire

@@ rtl/fbr_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none

module fbr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata <= mem_reg[addr];
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/fbr_front.sv @@
// Front end: accepts items, tracks the sprite position and turns items into clipped commands.
`default_nettype none

module fbr_front import fbr_pkg::*; (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [OP_W-1:0]         opcode,
    input  wire logic signed [POS_W-1:0] pos_x,
    input  wire logic signed [POS_W-1:0] pos_y,
    input  wire logic [SIZE_W-1:0]       size_w,
    input  wire logic [SIZE_W-1:0]       size_h,
    input  wire logic [PIX_W-1:0]        color,
    input  wire logic                    last_pixel,
    output logic                         q_push,
    output cmd_t                         q_cmd,
    input  wire logic                    q_ready
);

    function automatic logic [EXT_W-1:0] clamp_lim(input logic signed [EXT_W-1:0] v,
                                                   input logic signed [EXT_W-1:0] lim);
        logic [EXT_W-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > lim)
        begin
            r = lim;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    localparam logic signed [EXT_W-1:0] LIM_X = EXT_W'(SCREEN_WIDTH);
    localparam logic signed [EXT_W-1:0] LIM_Y = EXT_W'(SCREEN_HEIGHT);

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;

    logic                    accept;
    logic signed [EXT_W-1:0] px_ext, py_ext;
    logic signed [EXT_W-1:0] sx, sy;
    logic signed [EXT_W-1:0] fx_end, fy_end;
    logic [EXT_W-1:0]        fx0, fx1, fy0, fy1;
    logic                    spr_on, rd_on;
    logic [CNT_W:0]          col_inc;

    assign in_ready = q_ready;
    assign accept   = in_valid && in_ready;

    assign px_ext = EXT_W'(pos_x);
    assign py_ext = EXT_W'(pos_y);
    assign sx     = px_ext + signed'(EXT_W'(col_reg));
    assign sy     = py_ext + signed'(EXT_W'(row_reg));
    assign fx_end = px_ext + signed'(EXT_W'(size_w));
    assign fy_end = py_ext + signed'(EXT_W'(size_h));

    assign fx0 = clamp_lim(px_ext, LIM_X);
    assign fx1 = clamp_lim(fx_end, LIM_X);
    assign fy0 = clamp_lim(py_ext, LIM_Y);
    assign fy1 = clamp_lim(fy_end, LIM_Y);

    assign spr_on = (sx >= 0) && (sx < LIM_X) && (sy >= 0) && (sy < LIM_Y);
    assign rd_on  = (px_ext >= 0) && (px_ext < LIM_X) && (py_ext >= 0) && (py_ext < LIM_Y);

    always_comb
    begin
        q_cmd       = '0;
        q_cmd.color = color;
        q_push      = 1'b0;
        case (opcode_t'(opcode))
            OP_CLEAR:
            begin
                q_cmd.x1 = X_W'(SCREEN_WIDTH);
                q_cmd.y1 = Y_W'(SCREEN_HEIGHT);
                q_push   = accept;
            end
            OP_FILL:
            begin
                q_cmd.x0 = X_W'(fx0);
                q_cmd.x1 = X_W'(fx1);
                q_cmd.y0 = Y_W'(fy0);
                q_cmd.y1 = Y_W'(fy1);
                q_push   = accept && (fx0 < fx1) && (fy0 < fy1);
            end
            OP_SPRITE:
            begin
                q_cmd.x0 = X_W'(sx);
                q_cmd.x1 = X_W'(sx + EXT_W'(1));
                q_cmd.y0 = Y_W'(sy);
                q_cmd.y1 = Y_W'(sy + EXT_W'(1));
                q_push   = accept && spr_on;
            end
            OP_READ:
            begin
                q_cmd.is_read = 1'b1;
                q_cmd.rd_on   = rd_on;
                q_cmd.x0      = X_W'(pos_x);
                q_cmd.y0      = Y_W'(pos_y);
                q_push        = accept;
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    assign col_inc = {1'b0, col_reg} + (CNT_W + 1)'(1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept && (opcode_t'(opcode) == OP_SPRITE))
        begin
            if (last_pixel)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_inc >= {1'b0, size_w})
            begin
                col_next = '0;
                row_next = row_reg + CNT_W'(1);
            end
            else
            begin
                col_next = CNT_W'(col_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/fbr_queue.sv @@
// Command queue between front end and drawing back end.
`default_nettype none

module fbr_queue import fbr_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      push_ready,
    input  wire logic pop,
    output logic      pop_valid,
    output cmd_t      pop_cmd
);

    cmd_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]   cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign push_ready = (cnt_reg != (Q_PTR_W + 1)'(Q_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + Q_PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + Q_PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + (Q_PTR_W + 1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - (Q_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/fbr_back.sv @@
// Back end: sweeps rectangles into the frame memory and serves pixel reads.
`default_nettype none

module fbr_back import fbr_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire cmd_t               q_cmd,
    output logic                    q_pop,
    output logic                    ram_en,
    output logic                    ram_we,
    output logic [ADDR_W-1:0]       ram_addr,
    output logic [PIX_W-1:0]        ram_wdata,
    input  wire logic [PIX_W-1:0]   ram_rdata,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [PIX_W-1:0]        pixel_out
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DRAW = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               out_valid_reg, out_valid_next;
    logic               rd_zero_reg;
    logic [PIX_W-1:0]   pixel_reg;
    logic [X_W-1:0]     cx_reg, x0_reg, x1_reg;
    logic [Y_W-1:0]     cy_reg, y1_reg;
    logic [ADDR_W-1:0]  base_reg;
    logic [PIX_W-1:0]   color_reg;

    logic               drawing, row_end, draw_last, out_free, ld_read, ld_rect;
    logic [X_W-1:0]     cx_inc;
    logic [Y_W-1:0]     cy_inc;
    logic [ADDR_W-1:0]  row_base;

    assign drawing   = (state_reg == ST_DRAW);
    assign cx_inc    = cx_reg + X_W'(1);
    assign cy_inc    = cy_reg + Y_W'(1);
    assign row_end   = (cx_inc == x1_reg);
    assign draw_last = drawing && row_end && (cy_inc == y1_reg);
    assign out_free  = !out_valid_reg || out_ready;

    assign ld_read = q_valid && q_cmd.is_read && (state_reg == ST_IDLE) && !rd_pend_reg
                     && out_free;
    assign ld_rect = q_valid && !q_cmd.is_read && ((state_reg == ST_IDLE) || draw_last);
    assign q_pop   = ld_read || ld_rect;

    assign row_base  = ADDR_W'(q_cmd.y0) * ADDR_W'(SCREEN_WIDTH);
    assign ram_we    = drawing;
    assign ram_en    = drawing || (ld_read && q_cmd.rd_on);
    assign ram_addr  = drawing ? base_reg + ADDR_W'(cx_reg) : row_base + ADDR_W'(q_cmd.x0);
    assign ram_wdata = color_reg;

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ld_rect)
                begin
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                if (draw_last && !ld_rect)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_pend_next   = ld_read;
        out_valid_next = out_valid_reg;
        if (rd_pend_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_rect)
        begin
            cx_reg    <= q_cmd.x0;
            x0_reg    <= q_cmd.x0;
            x1_reg    <= q_cmd.x1;
            cy_reg    <= q_cmd.y0;
            y1_reg    <= q_cmd.y1;
            base_reg  <= row_base;
            color_reg <= q_cmd.color;
        end
        else if (drawing)
        begin
            if (row_end)
            begin
                cx_reg   <= x0_reg;
                cy_reg   <= cy_inc;
                base_reg <= base_reg + ADDR_W'(SCREEN_WIDTH);
            end
            else
            begin
                cx_reg <= cx_inc;
            end
        end
        if (ld_read)
        begin
            rd_zero_reg <= !q_cmd.rd_on;
        end
        if (rd_pend_reg)
        begin
            pixel_reg <= rd_zero_reg ? '0 : ram_rdata;
        end
    end

endmodule

`default_nettype wire

@@ verif/framebuffer_rect_fill_sprite_blit_tb.sv @@
// Testbench: directed rows and random drawing; directed reads check set values, others a shadow frame.
module framebuffer_rect_fill_sprite_blit_tb;
    import fbr_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 12;
    localparam int DIRECTED_ROWS  = 25;
    localparam int RANDOM_ITEMS   = 600;
    localparam int WRAP_LEN       = 1026;
    localparam int ITEM_TARGET    = DIRECTED_ROWS + RANDOM_ITEMS + WRAP_LEN;
    localparam int DRAIN_CYCLES   = 64;
    localparam int TIMEOUT_CYCLES = 5_000_000;
    localparam int MAX_SHOWN      = 30;

    typedef struct packed {
        opcode_t           op;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
        logic [PIX_W-1:0]  color;
        logic              last;
        logic              typed;
        logic [PIX_W-1:0]  want;
    } blit_cmd_t;

    typedef struct packed {
        logic [31:0]      seq;
        logic [PIX_W-1:0] pix;
    } pixel_due_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [OP_W-1:0]         opcode;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [SIZE_W-1:0]       size_w;
    logic [SIZE_W-1:0]       size_h;
    logic [PIX_W-1:0]        color;
    logic                    last_pixel;
    logic                    out_valid;
    logic                    out_ready;
    logic [PIX_W-1:0]        pixel_out;

    logic [PIX_W-1:0]  frame_shadow [PIXEL_COUNT];
    logic [CNT_W-1:0]  spr_col;
    logic [CNT_W-1:0]  spr_row;
    pixel_due_t        pending_pixels [$];
    pixel_due_t        due_now;

    int  items_sent     = 0;
    int  reads_issued   = 0;
    int  pixels_checked = 0;
    int  mismatch_count = 0;
    int  op_count [4]   = '{0, 0, 0, 0};
    int  hot_x          = 0;
    int  hot_y          = 0;
    int  big_fills_left = 6;
    int  random_clears  = 0;
    bit  wrap_done      = 1'b0;
    bit  in_idle_on     = 1'b1;
    bit  out_idle_on    = 1'b1;

    blit_cmd_t directed_rows [DIRECTED_ROWS] = '{
        '{OP_READ,   16'h8000, 16'h7FFF, 10'd0,    10'd0,    16'h0000, 1'b0, 1'b1, 16'h0000},
        '{OP_READ,   16'd320,  16'd0,    10'd0,    10'd0,    16'h0000, 1'b0, 1'b1, 16'h0000},
        '{OP_READ,   16'd0,    16'd240,  10'd0,    10'd0,    16'h0000, 1'b0, 1'b1, 16'h0000},
        '{OP_CLEAR,  16'd0,    16'd0,    10'd0,    10'd0,    16'hFFFF, 1'b0, 1'b0, 16'h0000},
        '{OP_READ,   16'd0,    16'd0,    10'd0,    10'd0,    16'h0000, 1'b0, 1'b1, 16'hFFFF},
        '{OP_READ,   16'd319,  16'd239,  10'd0,    10'd0,    16'h0000, 1'b0, 1'b1, 16'hFFFF},
        '{OP_FILL,   16'hFFFE, 16'hFFFD, 10'd10,   10'd10,   16'h1234, 1'b0, 1'b0, 16'h0000},
        '{OP_READ,   16'd0,    16'd0,    10'd0,    10'd0,    16'h0000, 1'b0, 1'b1, 16'h1234},
        '{OP_FILL,   16'd0,    16'd0,    10'd0,    10'd5,    16'h0000, 1'b0, 1'b0, 16'h0000},
        '{OP_FILL,   16'd0,    16'd0,    10'd5,    10'd0,    16'h0000, 1'b0, 1'b0, 16'h0000},
        '{OP_FILL,   16'h7FFF, 16'h7FFF, 10'd1023, 10'd1023, 16'h0000, 1'b0, 1'b0, 16'h0000},
        '{OP_READ,   16'd0,    16'd0,    10'd0,    10'd0,    16'h0000, 1'b0, 1'b1, 16'h1234},
        '{OP_FILL,   16'd315,  16'd235,  10'd1023, 10'd1023, 16'h8001, 1'b0, 1'b0, 16'h0000},
        '{OP_READ,   16'd319,  16'd239,  10'd0,    10'd0,    16'h0000, 1'b0, 1'b1, 16'h8001},
        '{OP_SPRITE, 16'd100,  16'd50,   10'd3,    10'd0,    16'h0F0F, 1'b0, 1'b0, 16'h0000},
        '{OP_SPRITE, 16'd100,  16'd50,   10'd3,    10'd0,    16'hF0F0, 1'b0, 1'b0, 16'h0000},
        '{OP_SPRITE, 16'd100,  16'd50,   10'd3,    10'd0,    16'h00FF, 1'b0, 1'b0, 16'h0000},
        '{OP_SPRITE, 16'd100,  16'd50,   10'd3,    10'd0,    16'hFF00, 1'b1, 1'b0, 16'h0000},
        '{OP_READ,   16'd100,  16'd51,   10'd0,    10'd0,    16'h0000, 1'b0, 1'b1, 16'hFF00},
        '{OP_SPRITE, 16'hFFFF, 16'd0,    10'd2,    10'd0,    16'h7777, 1'b0, 1'b0, 16'h0000},
        '{OP_SPRITE, 16'hFFFF, 16'd0,    10'd2,    10'd0,    16'h3C3C, 1'b1, 1'b0, 16'h0000},
        '{OP_READ,   16'd0,    16'd0,    10'd0,    10'd0,    16'h0000, 1'b0, 1'b1, 16'h3C3C},
        '{OP_SPRITE, 16'd318,  16'd238,  10'd0,    10'd0,    16'hAAAA, 1'b0, 1'b0, 16'h0000},
        '{OP_SPRITE, 16'd318,  16'd238,  10'd0,    10'd0,    16'h5555, 1'b1, 1'b0, 16'h0000},
        '{OP_READ,   16'd318,  16'd239,  10'd0,    10'd0,    16'h0000, 1'b0, 1'b1, 16'h5555}
    };

    framebuffer_rect_fill_sprite_blit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .size_w     (size_w),
        .size_h     (size_h),
        .color      (color),
        .last_pixel (last_pixel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_out  (pixel_out)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
        begin
            $display("%0t mismatch: %s", $time, msg);
        end
    endtask

    function automatic bit on_screen(input int x, input int y);
        return x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < SCREEN_HEIGHT;
    endfunction

    function automatic int edge_coord(input int k, input int lim);
        return (k == 0) ? -1 : (k == 1) ? 0 : (k == 2) ? lim - 1 : lim;
    endfunction

    function automatic blit_cmd_t scrambled_cmd(input opcode_t op);
        blit_cmd_t c;
        c.op    = op;
        c.x     = POS_W'($urandom_range(0, 65535));
        c.y     = POS_W'($urandom_range(0, 65535));
        c.w     = SIZE_W'($urandom_range(0, 1023));
        c.h     = SIZE_W'($urandom_range(0, 1023));
        c.color = PIX_W'($urandom_range(0, 65535));
        c.last  = 1'($urandom_range(0, 1));
        c.typed = 1'b0;
        c.want  = '0;
        return c;
    endfunction

    // Shadow of the frame memory and sprite counters, advanced one command at a time.
    task automatic apply_blit(input blit_cmd_t c);
        int px, py, pw, ph, x0, y0, x1, y1, dx, dy, col_i, row_i, r, k;
        pixel_due_t e;
        px    = int'($signed(c.x));
        py    = int'($signed(c.y));
        pw    = int'(c.w);
        ph    = int'(c.h);
        col_i = int'(spr_col);
        row_i = int'(spr_row);
        case (c.op)
            OP_CLEAR:
            begin
                for (k = 0; k < PIXEL_COUNT; k++)
                begin
                    frame_shadow[k] = c.color;
                end
            end
            OP_FILL:
            begin
                x0 = (px < 0) ? 0 : px;
                y0 = (py < 0) ? 0 : py;
                x1 = (px + pw > SCREEN_WIDTH) ? SCREEN_WIDTH : px + pw;
                y1 = (py + ph > SCREEN_HEIGHT) ? SCREEN_HEIGHT : py + ph;
                for (r = y0; r < y1; r++)
                begin
                    for (k = x0; k < x1; k++)
                    begin
                        frame_shadow[r * SCREEN_WIDTH + k] = c.color;
                    end
                end
            end
            OP_SPRITE:
            begin
                dx = px + col_i;
                dy = py + row_i;
                if (on_screen(dx, dy))
                begin
                    frame_shadow[dy * SCREEN_WIDTH + dx] = c.color;
                end
                if (c.last)
                begin
                    spr_col = '0;
                    spr_row = '0;
                end
                else if (col_i + 1 >= pw)
                begin
                    spr_col = '0;
                    spr_row = spr_row + 1'b1;
                end
                else
                begin
                    spr_col = spr_col + 1'b1;
                end
            end
            default:
            begin
                e.seq = reads_issued;
                if (c.typed)
                begin
                    e.pix = c.want;
                end
                else
                begin
                    e.pix = on_screen(px, py) ? frame_shadow[py * SCREEN_WIDTH + px] : '0;
                end
                pending_pixels.insert(pending_pixels.size(), e);
                reads_issued++;
            end
        endcase
    endtask

    task automatic issue(input blit_cmd_t c);
        int gap;
        if ($urandom_range(0, 39) == 0)
        begin
            in_idle_on = !in_idle_on;
        end
        gap = in_idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= c.op;
        pos_x      <= c.x;
        pos_y      <= c.y;
        size_w     <= c.w;
        size_h     <= c.h;
        color      <= c.color;
        last_pixel <= c.last;
        apply_blit(c);
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
        op_count[c.op]++;
    endtask

    task automatic read_pixel(input int x, input int y);
        blit_cmd_t c;
        c   = scrambled_cmd(OP_READ);
        c.x = x[POS_W-1:0];
        c.y = y[POS_W-1:0];
        issue(c);
    endtask

    task automatic random_reads();
        int n, i, sel;
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 40)
            begin
                read_pixel(hot_x + $urandom_range(0, 15) - 4, hot_y + $urandom_range(0, 15) - 4);
            end
            else if (sel < 75)
            begin
                read_pixel($urandom_range(0, SCREEN_WIDTH - 1),
                           $urandom_range(0, SCREEN_HEIGHT - 1));
            end
            else if (sel < 90)
            begin
                read_pixel(edge_coord($urandom_range(0, 3), SCREEN_WIDTH),
                           edge_coord($urandom_range(0, 3), SCREEN_HEIGHT));
            end
            else
            begin
                read_pixel($urandom_range(0, 65535), $urandom_range(0, 65535));
            end
        end
    endtask

    task automatic random_fill();
        blit_cmd_t c;
        int sel, x, y;
        c   = scrambled_cmd(OP_FILL);
        sel = $urandom_range(0, 99);
        if (sel < 12)
        begin
            // full-range origin and size: almost always clipped away entirely
        end
        else if (sel < 16 && big_fills_left > 0)
        begin
            big_fills_left--;
            x   = $urandom_range(0, 150) - 60;
            y   = $urandom_range(0, 120) - 60;
            c.x = x[POS_W-1:0];
            c.y = y[POS_W-1:0];
            c.w = SIZE_W'($urandom_range(150, 1023));
            c.h = SIZE_W'($urandom_range(100, 1023));
        end
        else
        begin
            x   = $urandom_range(0, SCREEN_WIDTH + 20) - 10;
            y   = $urandom_range(0, SCREEN_HEIGHT + 20) - 10;
            c.x = x[POS_W-1:0];
            c.y = y[POS_W-1:0];
            c.w = SIZE_W'($urandom_range(0, 16));
            c.h = SIZE_W'($urandom_range(0, 16));
        end
        issue(c);
        hot_x = int'($signed(c.x));
        hot_y = int'($signed(c.y));
        if ($urandom_range(0, 1) == 1)
        begin
            read_pixel(hot_x, hot_y);
            read_pixel(hot_x + int'(c.w) - 1, hot_y + int'(c.h) - 1);
        end
    endtask

    task automatic sprite_stream();
        blit_cmd_t c;
        int n, k, x, y;
        logic [SIZE_W-1:0] w;
        bit broken;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
        w = ($urandom_range(0, 9) == 0) ? SIZE_W'($urandom_range(0, 1023))
                                        : SIZE_W'($urandom_range(0, 12));
        if ($urandom_range(0, 4) == 0)
        begin
            x = int'($signed(16'($urandom_range(0, 65535))));
            y = int'($signed(16'($urandom_range(0, 65535))));
        end
        else
        begin
            x = $urandom_range(0, SCREEN_WIDTH + 7) - 8;
            y = $urandom_range(0, SCREEN_HEIGHT + 7) - 8;
        end
        broken = ($urandom_range(0, 7) == 0);
        for (k = 0; k < n; k++)
        begin
            c      = scrambled_cmd(OP_SPRITE);
            c.x    = x[POS_W-1:0];
            c.y    = y[POS_W-1:0];
            c.w    = w;
            c.last = (k == n - 1);
            if (broken && $urandom_range(0, 4) == 0)
            begin
                c.w    = SIZE_W'($urandom_range(0, 1023));
                c.x    = POS_W'(c.x + $urandom_range(0, 3));
                c.last = 1'($urandom_range(0, 1));
            end
            issue(c);
        end
        hot_x = x;
        hot_y = y;
        if ($urandom_range(0, 2) != 0)
        begin
            random_reads();
        end
    endtask

    // Width of zero or one steps the row on every pixel; 1026 pixels wrap the row count.
    task automatic row_wrap_stream();
        blit_cmd_t c;
        int k, x;
        c      = scrambled_cmd(OP_SPRITE);
        c.x    = 16'h8000;
        c.last = 1'b1;
        issue(c);
        x = $urandom_range(0, SCREEN_WIDTH - 1);
        for (k = 0; k < WRAP_LEN; k++)
        begin
            c      = scrambled_cmd(OP_SPRITE);
            c.x    = x[POS_W-1:0];
            c.y    = 16'd5;
            c.w    = SIZE_W'($urandom_range(0, 1));
            c.last = (k == WRAP_LEN - 1);
            issue(c);
        end
        read_pixel(x, 5);
        read_pixel(x, 6);
        read_pixel(x, 7);
        wrap_done = 1'b1;
    endtask

    task automatic stray_item();
        blit_cmd_t c;
        c = scrambled_cmd(($urandom_range(0, 1) == 1) ? OP_SPRITE : OP_READ);
        issue(c);
    endtask

    initial
    begin
        int sel, r;
        in_valid   <= 1'b0;
        opcode     <= OP_CLEAR;
        pos_x      <= '0;
        pos_y      <= '0;
        size_w     <= '0;
        size_h     <= '0;
        color      <= '0;
        last_pixel <= 1'b0;
        rst_n      <= 1'b0;
        spr_col     = '0;
        spr_row     = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < DIRECTED_ROWS; r++)
        begin
            issue(directed_rows[r]);
        end

        while (items_sent < ITEM_TARGET)
        begin
            if (!wrap_done && items_sent >= 300)
            begin
                row_wrap_stream();
            end
            else if (random_clears < 2 && items_sent >= 150 + 1200 * random_clears)
            begin
                random_clears++;
                issue(scrambled_cmd(OP_CLEAR));
            end
            else
            begin
                sel = $urandom_range(0, 99);
                if (sel < 40)
                begin
                    sprite_stream();
                end
                else if (sel < 65)
                begin
                    random_reads();
                end
                else if (sel < 90)
                begin
                    random_fill();
                end
                else
                begin
                    stray_item();
                end
            end
        end
        random_reads();
        in_valid <= 1'b0;

        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d commands: %0d clears, %0d fills, %0d sprite pixels, %0d reads",
                 items_sent, op_count[OP_CLEAR], op_count[OP_FILL],
                 op_count[OP_SPRITE], op_count[OP_READ]);
        $display("compared %0d read results, %0d mismatches", pixels_checked, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial
    begin
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                out_idle_on = !out_idle_on;
            end
            stall = out_idle_on ? $urandom_range(0, 12) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                report_mismatch($sformatf("pixel_out %h with no read pending", pixel_out));
            end
            else
            begin
                due_now = pending_pixels.pop_front();
                pixels_checked++;
                if (pixel_out !== due_now.pix)
                begin
                    report_mismatch($sformatf("read %0d: pixel_out %h, predicted %h",
                                              due_now.seq, pixel_out, due_now.pix));
                end
            end
        end
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/fbr_pkg.sv
rtl/fbr_ram.sv
rtl/fbr_front.sv
rtl/fbr_queue.sv
rtl/fbr_back.sv
rtl/framebuffer_rect_fill_sprite_blit.sv
verif/framebuffer_rect_fill_sprite_blit_tb.sv
